### hw/rtl/irmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irmt_pkg;

    // event codes on the input channel
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_EDGE    = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;
    localparam logic [1:0] CMD_TIMEOUT = 2'd3;

    // result action codes
    localparam logic [2:0] ACT_REJECT  = 3'd0;
    localparam logic [2:0] ACT_APPEND  = 3'd1;
    localparam logic [2:0] ACT_REPLACE = 3'd2;
    localparam logic [2:0] ACT_DELETE  = 3'd3;
    localparam logic [2:0] ACT_SEND    = 3'd4;
    localparam logic [2:0] ACT_FULL    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_GAP_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_EDGES     = 2'd1;
    localparam logic [1:0] REG_DOUBLE_SEND   = 2'd2;
    localparam logic [1:0] REG_FULL_WAIT     = 2'd3;

    // key characters
    localparam logic [7:0] KEY_SPACE   = 8'd32;
    localparam logic [7:0] KEY_UNKNOWN = 8'd63;
    localparam logic [7:0] KEY_NONE    = 8'd46;
    localparam logic [7:0] KEY_A       = 8'd97;
    localparam logic [7:0] KEY_D       = 8'd100;
    localparam logic [7:0] KEY_G       = 8'd103;
    localparam logic [7:0] KEY_J       = 8'd106;
    localparam logic [7:0] KEY_M       = 8'd109;
    localparam logic [7:0] KEY_P       = 8'd112;
    localparam logic [7:0] KEY_T       = 8'd116;
    localparam logic [7:0] KEY_W       = 8'd119;
    localparam logic [7:0] KEY_DELETE  = 8'd127;
    localparam logic [7:0] KEY_SEND    = 8'd128;

    // remote button codes
    localparam logic [7:0] CODE_SPACE  = 8'd255;
    localparam logic [7:0] CODE_ONE    = 8'd252;
    localparam logic [7:0] CODE_ABC    = 8'd253;
    localparam logic [7:0] CODE_DEF    = 8'd240;
    localparam logic [7:0] CODE_GHI    = 8'd247;
    localparam logic [7:0] CODE_JKL    = 8'd244;
    localparam logic [7:0] CODE_MNO    = 8'd241;
    localparam logic [7:0] CODE_PQRS   = 8'd192;
    localparam logic [7:0] CODE_TUV    = 8'd223;
    localparam logic [7:0] CODE_WXYZ   = 8'd220;
    localparam logic [7:0] CODE_DELETE = 8'd196;
    localparam logic [7:0] CODE_SEND   = 8'd130;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] timestamp;
        logic [31:0] wait_ticks;
    } in_word_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_code;
        logic [7:0] position;
        logic [7:0] raw_code;
    } out_word_t;

    // datapath micro-operations
    typedef enum logic [2:0] {
        U_EVENT  = 3'd0,  // take a word, handle start, edge and timeout at once
        U_OPEN   = 3'd1,  // disarm, set up the stamp walk
        U_NOP    = 3'd2,
        U_READ   = 3'd3,  // read one stamp, advance read pointer
        U_ACCUM  = 3'd4,  // gap compare, shift one code bit
        U_KEY    = 3'd5,  // map code to key
        U_TAP    = 3'd6,  // multi-tap action, emit result
        U_REJECT = 3'd7   // emit rejected frame
    } uop_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_END    = 3'd2,
        C_NOT_ARMED = 3'd3,
        C_BAD_FRAME = 3'd4,
        C_MORE      = 3'd5
    } cond_t;

    localparam int PC_W = 3;

    typedef struct packed {
        uop_t            uop;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            emit;
    } ctrl_word_t;

    // sequencer to datapath
    typedef struct packed {
        uop_t uop;
        logic fire;
        logic idle;
    } seq_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic frame_end;
        logic not_armed;
        logic bad_frame;
        logic more;
        logic out_free;
    } seq_status_t;

    function automatic logic [7:0] key_of(input logic [7:0] code);
        logic [7:0] k;
        case (code)
            CODE_SPACE:  k = KEY_SPACE;
            CODE_ONE:    k = KEY_UNKNOWN;
            CODE_ABC:    k = KEY_A;
            CODE_DEF:    k = KEY_D;
            CODE_GHI:    k = KEY_G;
            CODE_JKL:    k = KEY_J;
            CODE_MNO:    k = KEY_M;
            CODE_PQRS:   k = KEY_P;
            CODE_TUV:    k = KEY_T;
            CODE_WXYZ:   k = KEY_W;
            CODE_DELETE: k = KEY_DELETE;
            CODE_SEND:   k = KEY_SEND;
            default:     k = KEY_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ir_remote_multitap_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// ir remote multi-tap decoder
// input channel (in_valid / in_stall / in_data) carries receiver event words:
//   frame start with the idle timer reading, edge with its timestamp,
//   frame end, idle timeout
// start, edge and timeout words are handled in the idle step and give no result
// a frame end word starts a microcoded walk over the stamp window:
//   a registered memory read, then a gap compare, for each stamp
// the block takes no new word (in_stall high) while the walk runs
// output channel (out_valid / out_stall / out_data) gives at most one word per
//   frame end from an output register; while the receiver stalls, the word holds
//   and a following result step waits, but start, edge and timeout words are
//   still taken
// configuration writes (cfg_valid / cfg_ready) are always ready and are meant
//   for an idle block
// reset clears the sequencer, the key state and the registers to their defaults;
//   the stamp window is not cleared, only stamps of the current frame are read
module ir_remote_multitap_decoder_core #(
    parameter int WINDOW     = 8,
    parameter int MSG_LEN    = 256,
    parameter int EDGE_LIMIT = 128
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  irmt_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output irmt_pkg::out_word_t  out_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [1:0]            cfg_index,
    input  wire [31:0]           cfg_data
);
    import irmt_pkg::*;

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [7:0] WINDOW_8   = 8'(WINDOW);
    localparam logic [7:0] EDGE_LIM_8 = 8'(EDGE_LIMIT);
    localparam logic [7:0] MSG_LIMIT  = (MSG_LEN - 1 > 255) ? 8'd255 : 8'(MSG_LEN - 1);

    seq_ctrl_t   ctrl;
    seq_status_t status;

    // config registers
    logic [31:0] gap_thr_reg,   gap_thr_next;
    logic [7:0]  min_edges_reg, min_edges_next;
    logic [31:0] ds_limit_reg,  ds_limit_next;
    logic [31:0] full_wait_reg, full_wait_next;

    // frame capture state
    logic             armed_reg,      armed_next;
    logic [7:0]       edge_total_reg, edge_total_next;
    logic [PTR_W-1:0] wr_ptr_reg,     wr_ptr_next;

    // stamp walk
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] k_reg,      k_next;
    logic             first_reg,  first_next;
    logic             bit_reg,    bit_next;
    logic [7:0]       code_reg,   code_next;
    logic [31:0]      prev_reg,   prev_next;
    logic [7:0]       key_reg,    key_next;
    logic [31:0]      rd_data_reg;

    // key state
    logic       new_letter_reg, new_letter_next;
    logic [7:0] last_key_reg,   last_key_next;
    logic [1:0] tap_reg,        tap_next;
    logic [7:0] cursor_reg,     cursor_next;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg,  out_data_next;

    logic [31:0] stamp_mem [WINDOW];

    logic in_fire;
    logic out_free;
    logic step;
    logic mem_we;
    logic rd_en;
    logic [31:0] gap;
    logic toggle;
    logic [7:0] cur_dec;
    logic [1:0] tap_inc;

    assign in_stall  = !ctrl.idle;
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = ctrl.fire;
    assign cfg_ready = 1'b1;

    assign status.frame_end = in_fire && (in_data.cmd == CMD_END);
    assign status.not_armed = !armed_reg;
    assign status.bad_frame = (edge_total_reg <= min_edges_reg) || (edge_total_reg < WINDOW_8);
    assign status.more      = (k_reg != PTR_LAST);
    assign status.out_free  = out_free;

    irmt_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // wrapping stamp difference, the first stamp never toggles
    assign gap     = rd_data_reg - prev_reg;
    assign toggle  = !first_reg && (gap > gap_thr_reg);
    assign cur_dec = (cursor_reg == 8'd0) ? 8'd0 : cursor_reg - 8'd1;

    // tap count wraps at 4 on the four-letter keys, else at 3
    always_comb
    begin
        if (key_reg == KEY_P || key_reg == KEY_W)
        begin
            tap_inc = tap_reg + 2'd1;
        end
        else
        begin
            case (tap_reg)
                2'd0:    tap_inc = 2'd1;
                2'd1:    tap_inc = 2'd2;
                2'd2:    tap_inc = 2'd0;
                default: tap_inc = 2'd1;
            endcase
        end
    end

    always_comb
    begin
        gap_thr_next    = gap_thr_reg;
        min_edges_next  = min_edges_reg;
        ds_limit_next   = ds_limit_reg;
        full_wait_next  = full_wait_reg;
        armed_next      = armed_reg;
        edge_total_next = edge_total_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        k_next          = k_reg;
        first_next      = first_reg;
        bit_next        = bit_reg;
        code_next       = code_reg;
        prev_next       = prev_reg;
        key_next        = key_reg;
        new_letter_next = new_letter_reg;
        last_key_next   = last_key_reg;
        tap_next        = tap_reg;
        cursor_next     = cursor_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_we          = 1'b0;
        rd_en           = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAP_THRESHOLD: gap_thr_next   = cfg_data;
                REG_MIN_EDGES:     min_edges_next = cfg_data[7:0];
                REG_DOUBLE_SEND:   ds_limit_next  = cfg_data;
                REG_FULL_WAIT:     full_wait_next = cfg_data;
                default:           gap_thr_next   = gap_thr_reg;
            endcase
        end

        if (step)
        begin
            case (ctrl.uop)
                U_EVENT:
                begin
                    if (in_fire)
                    begin
                        case (in_data.cmd)
                            CMD_START:
                            begin
                                edge_total_next = 8'd0;
                                wr_ptr_next     = '0;
                                armed_next      = (in_data.wait_ticks < ds_limit_reg) ||
                                                  (in_data.wait_ticks == full_wait_reg);
                            end
                            CMD_EDGE:
                            begin
                                if (armed_reg && edge_total_reg < EDGE_LIM_8)
                                begin
                                    mem_we          = 1'b1;
                                    edge_total_next = edge_total_reg + 8'd1;
                                    wr_ptr_next     = (wr_ptr_reg == PTR_LAST) ? '0 :
                                                      wr_ptr_reg + 1'b1;
                                end
                            end
                            CMD_TIMEOUT:
                            begin
                                new_letter_next = 1'b1;
                            end
                            default:
                            begin
                                // frame end is taken up by the microprogram
                                armed_next = armed_reg;
                            end
                        endcase
                    end
                end
                U_OPEN:
                begin
                    armed_next  = 1'b0;
                    rd_ptr_next = wr_ptr_reg;   // oldest stamp of the window
                    k_next      = '0;
                    first_next  = 1'b1;
                    bit_next    = 1'b1;
                    code_next   = 8'd0;
                end
                U_READ:
                begin
                    rd_en       = 1'b1;
                    rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                end
                U_ACCUM:
                begin
                    bit_next   = bit_reg ^ toggle;
                    code_next  = {code_reg[6:0], bit_reg ^ toggle};
                    prev_next  = rd_data_reg;
                    first_next = 1'b0;
                    k_next     = k_reg + 1'b1;
                end
                U_KEY:
                begin
                    key_next = key_of(code_reg);
                end
                U_TAP:
                begin
                    out_valid_next  = 1'b1;
                    last_key_next   = key_reg;
                    new_letter_next = 1'b0;
                    if (key_reg == KEY_DELETE)
                    begin
                        cursor_next   = cur_dec;
                        out_data_next = '{ACT_DELETE, 8'd0, cur_dec, code_reg};
                    end
                    else if (key_reg == KEY_SEND)
                    begin
                        cursor_next   = 8'd0;
                        out_data_next = '{ACT_SEND, KEY_NONE, cursor_reg, code_reg};
                    end
                    else if (key_reg == KEY_SPACE || new_letter_reg || key_reg != last_key_reg)
                    begin
                        tap_next = 2'd0;
                        if (cursor_reg >= MSG_LIMIT)
                        begin
                            out_data_next = '{ACT_FULL, key_reg, cursor_reg, code_reg};
                        end
                        else
                        begin
                            out_data_next = '{ACT_APPEND, key_reg, cursor_reg, code_reg};
                            cursor_next   = cursor_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        // same key again: cycle the letter in place
                        tap_next      = tap_inc;
                        out_data_next = '{ACT_REPLACE, key_reg + {6'd0, tap_inc}, cur_dec,
                                          code_reg};
                        cursor_next   = cur_dec + 8'd1;
                    end
                end
                U_REJECT:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{ACT_REJECT, 8'd0, 8'd0, 8'd0};
                end
                default:
                begin
                    key_next = key_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_thr_reg    <= 32'd100000;
            min_edges_reg  <= 8'd20;
            ds_limit_reg   <= 32'd64000000;
            full_wait_reg  <= 32'd80000000;
            armed_reg      <= 1'b0;
            edge_total_reg <= 8'd0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            k_reg          <= '0;
            first_reg      <= 1'b1;
            new_letter_reg <= 1'b1;
            last_key_reg   <= KEY_NONE;
            tap_reg        <= 2'd0;
            cursor_reg     <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            gap_thr_reg    <= gap_thr_next;
            min_edges_reg  <= min_edges_next;
            ds_limit_reg   <= ds_limit_next;
            full_wait_reg  <= full_wait_next;
            armed_reg      <= armed_next;
            edge_total_reg <= edge_total_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            k_reg          <= k_next;
            first_reg      <= first_next;
            new_letter_reg <= new_letter_next;
            last_key_reg   <= last_key_next;
            tap_reg        <= tap_next;
            cursor_reg     <= cursor_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bit_reg      <= bit_next;
        code_reg     <= code_next;
        prev_reg     <= prev_next;
        key_reg      <= key_next;
        out_data_reg <= out_data_next;
    end

    // stamp window memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stamp_mem[wr_ptr_reg] <= in_data.timestamp;
        end
        if (rd_en)
        begin
            rd_data_reg <= stamp_mem[rd_ptr_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### hw/rtl/irmt_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module irmt_seq (
    input  wire                    clk,
    input  wire                    rst_n,
    input  irmt_pkg::seq_status_t  status,
    output irmt_pkg::seq_ctrl_t    ctrl
);
    import irmt_pkg::*;

    localparam logic [PC_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [PC_W-1:0] ST_OPEN   = 3'd1;
    localparam logic [PC_W-1:0] ST_CHECK  = 3'd2;
    localparam logic [PC_W-1:0] ST_READ   = 3'd3;
    localparam logic [PC_W-1:0] ST_ACCUM  = 3'd4;
    localparam logic [PC_W-1:0] ST_KEY    = 3'd5;
    localparam logic [PC_W-1:0] ST_TAP    = 3'd6;
    localparam logic [PC_W-1:0] ST_REJECT = 3'd7;

    // microprogram
    function automatic ctrl_word_t rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            ST_IDLE:   w = '{U_EVENT,  C_NO_END,    ST_IDLE,   1'b0};
            ST_OPEN:   w = '{U_OPEN,   C_NOT_ARMED, ST_IDLE,   1'b0};
            ST_CHECK:  w = '{U_NOP,    C_BAD_FRAME, ST_REJECT, 1'b0};
            ST_READ:   w = '{U_READ,   C_NEXT,      ST_IDLE,   1'b0};
            ST_ACCUM:  w = '{U_ACCUM,  C_MORE,      ST_READ,   1'b0};
            ST_KEY:    w = '{U_KEY,    C_NEXT,      ST_IDLE,   1'b0};
            ST_TAP:    w = '{U_TAP,    C_ALWAYS,    ST_IDLE,   1'b1};
            ST_REJECT: w = '{U_REJECT, C_ALWAYS,    ST_IDLE,   1'b1};
            default:   w = '{U_NOP,    C_ALWAYS,    ST_IDLE,   1'b0};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ctrl_word_t      word;
    logic            hold;
    logic            taken;

    assign word = rom(pc_reg);
    // a result step waits for a free output register
    assign hold = word.emit && !status.out_free;

    always_comb
    begin
        case (word.cond)
            C_NEXT:      taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_END:    taken = !status.frame_end;
            C_NOT_ARMED: taken = status.not_armed;
            C_BAD_FRAME: taken = status.bad_frame;
            C_MORE:      taken = status.more;
            default:     taken = 1'b1;
        endcase
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.uop  = word.uop;
    assign ctrl.fire = !hold;
    assign ctrl.idle = (pc_reg == ST_IDLE);

endmodule

`default_nettype wire

### hw/rtl/irmt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module irmt_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  in_valid,
    input wire                  in_stall,
    input irmt_pkg::in_word_t   in_data,
    input wire                  out_valid,
    input wire                  out_stall,
    input irmt_pkg::out_word_t  out_data
);
    import irmt_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed under stall");

    // frame end starts the walk, no word is taken next cycle
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.cmd == CMD_END |=> in_stall)
        else $error("block took a word right after frame end");

    // a new result only comes out of the walk
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a frame walk");

    // rejected frame carries all zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action == ACT_REJECT |->
            out_data.char_code == 8'd0 && out_data.position == 8'd0 &&
            out_data.raw_code == 8'd0)
        else $error("rejected frame with nonzero fields");

endmodule

bind ir_remote_multitap_decoder_core irmt_checker u_irmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

### tb/ir_remote_multitap_decoder_core_tb.sv
`timescale 1ns / 1ps

module ir_remote_multitap_decoder_core_tb;
    import irmt_pkg::*;

    localparam int WINDOW     = 8;
    localparam int MSG_LEN    = 256;
    localparam int EDGE_LIMIT = 128;
    localparam int MSG_LAST   = ((MSG_LEN > 256) ? 256 : MSG_LEN) - 1;

    // settle time before a register write, long enough for the stamp walk to finish
    localparam int SETTLE_CYCLES = 4 * WINDOW + 8;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    // remote buttons, index 0 first; delete and send are the two last ones
    localparam logic [12*8-1:0] BUTTON_CODES = {CODE_SEND, CODE_DELETE, CODE_WXYZ, CODE_TUV,
        CODE_PQRS, CODE_MNO, CODE_JKL, CODE_GHI, CODE_DEF, CODE_ABC, CODE_ONE, CODE_SPACE};
    localparam logic [12*8-1:0] BUTTON_KEYS = {KEY_SEND, KEY_DELETE, KEY_W, KEY_T,
        KEY_P, KEY_M, KEY_J, KEY_G, KEY_D, KEY_A, KEY_UNKNOWN, KEY_SPACE};
    localparam int LETTER_BUTTONS = 10;

    typedef enum logic [1:0] {
        OP_WORD,   // one receiver event word
        OP_CFG,    // one register write
        OP_DRAIN   // hold off until every decoded action is back, then settle
    } stim_kind_t;

    typedef struct {
        stim_kind_t      kind;
        in_word_t        word;
        logic [1:0]      reg_idx;
        logic [31:0]     reg_val;
    } stim_op_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_word_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    ir_remote_multitap_decoder_core #(
        .WINDOW     (WINDOW),
        .MSG_LEN    (MSG_LEN),
        .EDGE_LIMIT (EDGE_LIMIT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // decoder shadow: registers as written, frame and multi-tap state
    // ------------------------------------------------------------------
    logic [31:0] thr_gap    = 32'd100000;
    logic [7:0]  thr_edges  = 8'd20;
    logic [31:0] thr_resend = 32'd64000000;
    logic [31:0] thr_expiry = 32'd80000000;

    logic        armed      = 1'b0;
    int          edge_cnt   = 0;
    logic [31:0] stamps [WINDOW];
    logic        new_letter = 1'b1;
    logic [7:0]  last_key   = KEY_NONE;
    int          taps       = 0;
    logic [7:0]  cursor_pos = '0;

    out_word_t   actions_due [$];
    stim_op_t    rx_events [$];
    int          errors       = 0;
    int          words_taken  = 0;
    int          queued_words = 0;
    logic        quiet        = 1'b0;

    // generator copy of the settings, used only to shape frames
    logic [31:0] plan_gap    = 32'd100000;
    logic [31:0] plan_resend = 32'd64000000;
    logic [31:0] plan_expiry = 32'd80000000;
    logic [7:0]  last_pick   = CODE_SPACE;

    function automatic logic [7:0] key_for_code(input logic [7:0] code);
        for (int i = 0; i < 12; i++)
            if (BUTTON_CODES[i*8 +: 8] == code)
                return BUTTON_KEYS[i*8 +: 8];
        return KEY_UNKNOWN;
    endfunction

    task automatic write_shadow(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_GAP_THRESHOLD: thr_gap    = val;
            REG_MIN_EDGES:     thr_edges  = val[7:0];
            REG_DOUBLE_SEND:   thr_resend = val;
            REG_FULL_WAIT:     thr_expiry = val;
            default: ;
        endcase
    endtask

    // one accepted event word in, at most one expected action out
    task automatic decode_event(input in_word_t w);
        out_word_t   res;
        logic [7:0]  code;
        logic [7:0]  key;
        logic [7:0]  spot;
        logic [31:0] prev;
        logic [31:0] s;
        logic        level;
        case (w.cmd)
            CMD_START:
            begin
                edge_cnt = 0;
                armed = (w.wait_ticks < thr_resend) || (w.wait_ticks == thr_expiry);
            end
            CMD_EDGE:
            begin
                if (armed && edge_cnt < EDGE_LIMIT)
                begin
                    stamps[edge_cnt % WINDOW] = w.timestamp;
                    edge_cnt++;
                end
            end
            CMD_TIMEOUT: new_letter = 1'b1;
            CMD_END:
            begin
                if (armed)
                begin
                    armed = 1'b0;
                    if (edge_cnt <= int'(thr_edges) || edge_cnt < WINDOW)
                    begin
                        res = '{action: ACT_REJECT, default: '0};
                    end
                    else
                    begin
                        // oldest stamp first; a long gap flips the bit level
                        code  = '0;
                        level = 1'b1;
                        prev  = stamps[edge_cnt % WINDOW];
                        for (int k = 0; k < WINDOW; k++)
                        begin
                            s = stamps[(edge_cnt + k) % WINDOW];
                            if (s - prev > thr_gap)
                                level = ~level;
                            prev = s;
                            code = {code[6:0], level};
                        end
                        key = key_for_code(code);
                        res.raw_code = code;
                        if (key == KEY_DELETE)
                        begin
                            if (cursor_pos != 0)
                                cursor_pos--;
                            res.action    = ACT_DELETE;
                            res.char_code = '0;
                            res.position  = cursor_pos;
                        end
                        else if (key == KEY_SEND)
                        begin
                            res.action    = ACT_SEND;
                            res.char_code = KEY_NONE;
                            res.position  = cursor_pos;
                            cursor_pos    = '0;
                        end
                        else if (key == KEY_SPACE || new_letter || key != last_key)
                        begin
                            taps = 0;
                            res.char_code = key;
                            res.position  = cursor_pos;
                            if (cursor_pos >= MSG_LAST)
                            begin
                                res.action = ACT_FULL;
                            end
                            else
                            begin
                                res.action = ACT_APPEND;
                                cursor_pos++;
                            end
                        end
                        else
                        begin
                            // same key again: cycle through its letters
                            taps = (taps + 1) % ((key == KEY_P || key == KEY_W) ? 4 : 3);
                            spot = (cursor_pos == 0) ? 8'd0 : cursor_pos - 8'd1;
                            res.action    = ACT_REPLACE;
                            res.char_code = key + 8'(taps);
                            res.position  = spot;
                            cursor_pos    = spot + 8'd1;
                        end
                        last_key   = key;
                        new_letter = 1'b0;
                    end
                    actions_due.push_back(res);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver: event words and register writes from the pending queue
    // ------------------------------------------------------------------
    int settle_cnt = 0;

    always @(posedge clk)
    begin
        logic     nxt_valid;
        logic     nxt_cfg;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_cfg   = cfg_valid;
            if (in_valid && !in_stall)
            begin
                decode_event(in_data);
                words_taken++;
                nxt_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                write_shadow(cfg_index, cfg_data);
                nxt_cfg = 1'b0;
            end
            if (!nxt_valid && !nxt_cfg && rx_events.size() != 0)
            begin
                case (rx_events[0].kind)
                    OP_WORD:
                    begin
                        if (quiet || $urandom_range(99, 0) >= 15)
                        begin
                            nxt_valid = 1'b1;
                            in_data <= rx_events[0].word;
                            void'(rx_events.pop_front());
                        end
                    end
                    OP_CFG:
                    begin
                        nxt_cfg = 1'b1;
                        cfg_index <= rx_events[0].reg_idx;
                        cfg_data  <= rx_events[0].reg_val;
                        void'(rx_events.pop_front());
                    end
                    default:
                    begin
                        // hold off until every action is back and the walk is surely over
                        if (actions_due.size() != 0)
                            settle_cnt = 0;
                        else if (settle_cnt < SETTLE_CYCLES)
                            settle_cnt++;
                        else
                        begin
                            settle_cnt = 0;
                            void'(rx_events.pop_front());
                        end
                    end
                endcase
            end
            in_valid  <= nxt_valid;
            cfg_valid <= nxt_cfg;
            // one stretch early in the run where neither side idles
            quiet <= (words_taken >= 30 && words_taken < 300);
        end
    end

    // ------------------------------------------------------------------
    // monitor: compare each taken action word with the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(input string label, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (actions_due.size() == 0)
                begin
                    $display("%0t ns: unexpected action word, expected none, got %h",
                             $time, out_data);
                    errors++;
                end
                else
                begin
                    want = actions_due.pop_front();
                    check_field("action", 8'(want.action), 8'(out_data.action));
                    check_field("char_code", want.char_code, out_data.char_code);
                    check_field("position", want.position, out_data.position);
                    check_field("raw_code", want.raw_code, out_data.raw_code);
                end
            end
            out_stall <= quiet ? 1'b0 : ($urandom_range(99, 0) < 15);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_word(input logic [1:0] cmd, input logic [31:0] ts,
                             input logic [31:0] wt);
        stim_op_t op;
        op.kind            = OP_WORD;
        op.word.cmd        = cmd;
        op.word.timestamp  = ts;
        op.word.wait_ticks = wt;
        op.reg_idx         = '0;
        op.reg_val         = '0;
        rx_events.push_back(op);
        queued_words++;
    endtask

    task automatic hold_for_results();
        stim_op_t op;
        op = '{OP_DRAIN, '0, '0, '0};
        rx_events.push_back(op);
    endtask

    task automatic set_config(input logic [31:0] gap, input logic [7:0] min_e,
                              input logic [31:0] resend, input logic [31:0] expiry);
        stim_op_t op;
        hold_for_results();
        op = '{OP_CFG, '0, REG_GAP_THRESHOLD, gap};
        rx_events.push_back(op);
        op = '{OP_CFG, '0, REG_MIN_EDGES, {24'd0, min_e}};
        rx_events.push_back(op);
        op = '{OP_CFG, '0, REG_DOUBLE_SEND, resend};
        rx_events.push_back(op);
        op = '{OP_CFG, '0, REG_FULL_WAIT, expiry};
        rx_events.push_back(op);
        plan_gap    = gap;
        plan_resend = resend;
        plan_expiry = expiry;
    endtask

    task automatic drain_stimulus();
        while (rx_events.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] good_wait();
        if (plan_resend != 0 && $urandom_range(3, 0) != 0)
            return $urandom_range(plan_resend - 32'd1, 0);
        return plan_expiry;
    endfunction

    function automatic logic [31:0] bad_wait();
        logic [31:0] w;
        w = $urandom_range(32'hFFFF_FFFF, plan_resend);
        if (w == plan_expiry)
            w = w + 32'd1;
        return w;
    endfunction

    // mostly real buttons, repeats for multi-tap, now and then a stray code
    function automatic logic [7:0] pick_code(input logic fill);
        int idx;
        if (!fill && $urandom_range(99, 0) < 35)
            return last_pick;
        if ($urandom_range(99, 0) < 6)
            return 8'h80 | 8'($urandom);
        idx = fill ? $urandom_range(LETTER_BUTTONS - 1, 0) : $urandom_range(11, 0);
        last_pick = BUTTON_CODES[idx*8 +: 8];
        return last_pick;
    endfunction

    // start, edges, end; the last recorded WINDOW stamps are spaced to spell the code
    task automatic add_frame(input logic [7:0] code, input int n_edges,
                             input logic [31:0] start_wait);
        logic [31:0] stamp;
        logic        flip;
        int          kept;
        int          k;
        stamp = $urandom;
        kept  = (n_edges > EDGE_LIMIT) ? EDGE_LIMIT : n_edges;
        push_word(CMD_START, $urandom, start_wait);
        for (int i = 0; i < n_edges; i++)
        begin
            k = i - (kept - WINDOW);
            if (k >= 1 && k < WINDOW)
            begin
                flip  = code[WINDOW - k] ^ code[WINDOW - 1 - k];
                stamp = stamp + (flip ? plan_gap + 32'd1 + $urandom_range(4095, 0)
                                      : (($urandom_range(3, 0) == 0) ? plan_gap
                                                                     : $urandom_range(plan_gap, 0)));
            end
            else
                stamp = stamp + $urandom;
            push_word(CMD_EDGE, stamp, $urandom);
        end
        push_word(CMD_END, $urandom, $urandom);
    endtask

    // well-formed frames with random content, plus broken frames and stray words
    task automatic run_mix(input int n_words, input int lo, input int hi, input logic fill);
        int stop;
        int r;
        stop = queued_words + n_words;
        while (queued_words < stop)
        begin
            r = $urandom_range(fill ? 71 : 99, 0);
            if ($urandom_range(99, 0) < 2)
                hold_for_results();
            if (r < 70)
                add_frame(pick_code(fill), $urandom_range(hi, lo), good_wait());
            else if (r < 76)
            begin
                // start again while armed, a few edges that get thrown away
                push_word(CMD_START, $urandom, good_wait());
                repeat ($urandom_range(3, 0))
                    push_word(CMD_EDGE, $urandom, $urandom);
                add_frame(pick_code(fill), $urandom_range(hi, lo), good_wait());
            end
            else if (r < 82)
                add_frame(pick_code(fill), $urandom_range(WINDOW - 1, 0), good_wait());
            else if (r < 87)
                add_frame(pick_code(fill), $urandom_range(hi, lo), bad_wait());
            else if (r < 93)
                push_word(CMD_TIMEOUT, $urandom, $urandom);
            else
                push_word(2'($urandom), $urandom, $urandom);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle corners at reset settings
        push_word(CMD_TIMEOUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(CMD_EDGE, 32'h0, 32'h0);                  // not armed, dropped
        push_word(CMD_END, 32'h0, 32'h0);                   // not armed, silent
        push_word(CMD_START, 32'h0, 32'hFFFF_FFFF);         // rejected start
        push_word(CMD_START, 32'h0, 32'd64_000_000);        // right at the resend limit
        push_word(CMD_START, 32'h0, 32'd80_000_000);        // timer fully expired: armed
        push_word(CMD_START, 32'h0, 32'd63_999_999);        // start again while armed
        push_word(CMD_EDGE, 32'hFFFF_FFFF, 32'h0);
        push_word(CMD_END, 32'h0, 32'h0);                   // too few edges: rejected frame
        set_config(32'd100000, 8'd7, 32'd64_000_000, 32'd80_000_000);
        add_frame(CODE_DELETE, WINDOW, 32'd0);              // delete with the cursor at 0

        // reset-like settings, long frames
        set_config(32'd100000, 8'd20, 32'd64_000_000, 32'd80_000_000);
        run_mix(150, 21, 26, 1'b0);

        // short frames, plenty of send and delete
        set_config(32'd2500, 8'd3, 32'd1_000_000, 32'hFFFF_FFFE);
        run_mix(250, WINDOW, WINDOW + 4, 1'b0);

        // no delete or send buttons, long runs of appends
        set_config(32'd700, 8'd7, 32'd50000, 32'd0);
        run_mix(260, WINDOW, WINDOW + 1, 1'b1);
        hold_for_results();

        // every stamp gap counts, only the max idle reading arms
        set_config(32'd0, 8'd0, 32'd0, 32'hFFFF_FFFF);
        run_mix(120, WINDOW - 4, WINDOW + 2, 1'b0);

        // nothing toggles and no frame is long enough; edges past the limit
        set_config(32'hFFFF_FFFF, 8'd128, 32'hFFFF_FFFF, 32'd0);
        add_frame(pick_code(1'b0), EDGE_LIMIT + 5, good_wait());
        run_mix(40, WINDOW, WINDOW + 4, 1'b0);

        // frames that just clear the edge minimum at the limit
        set_config(32'd45000, 8'd127, 32'h8000_0000, 32'h9000_0000);
        add_frame(CODE_TUV, EDGE_LIMIT, good_wait());
        add_frame(pick_code(1'b0), EDGE_LIMIT + 12, good_wait());

        // random settings
        set_config($urandom_range(400000, 0), 8'($urandom_range(12, 0)), $urandom, $urandom);
        run_mix(200, WINDOW, WINDOW + 6, 1'b0);

        hold_for_results();
        drain_stimulus();

        if (errors == 0 && actions_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hw/rtl/irmt_pkg.sv
hw/rtl/irmt_seq.sv
hw/rtl/ir_remote_multitap_decoder_core.sv
hw/rtl/irmt_checker.sv
tb/ir_remote_multitap_decoder_core_tb.sv
